// ===== rtl/lif_neuron_population_update_assert.svh =====
// Assertion macros for the leaky integrate-and-fire population update block.
// Depends on nothing; included by the top level, which holds the assertions.
// Under SYNTHESIS the macros expand to nothing.
`ifndef LIF_NEURON_POPULATION_UPDATE_ASSERT_SVH
`define LIF_NEURON_POPULATION_UPDATE_ASSERT_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define LNPU_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define LNPU_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");
`else
`define LNPU_ASSERT_SAME(name, clk, rst, ante, cons)
`define LNPU_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/lnpu_pkg.sv =====
// Shared types and constants for the leaky integrate-and-fire population update.
// Depends on nothing; imported by lif_neuron_population_update.
package lnpu_pkg;

   // Default population size.
   localparam int NEURONS_DEFAULT = 256;

   // Field widths.
   localparam int INDEX_W     = 8;
   localparam int NOISE_W     = 16;
   localparam int WORD_W      = 32;
   localparam int DECAY_W     = 17;
   localparam int TICKS_W     = 16;
   localparam int CSR_INDEX_W = 3;

   // Register reset values.
   localparam logic [DECAY_W-1:0] DECAY_RESET     = 17'h10000;
   localparam logic [WORD_W-1:0]  THRESHOLD_RESET = 32'h0001_0000;
   localparam logic [TICKS_W-1:0] BIN_TICKS_RESET = 16'd1;

   // Width of the exact sum with 32 fraction bits.
   localparam int SUM_W = 54;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DECAY            = 3'd0,
      CSR_COMMON_GAIN      = 3'd1,
      CSR_PRIVATE_GAIN     = 3'd2,
      CSR_DRIVE_TERM       = 3'd3,
      CSR_THRESHOLD        = 3'd4,
      CSR_RESET_VOLTAGE    = 3'd5,
      CSR_REFRACTORY_TICKS = 3'd6,
      CSR_BIN_TICKS        = 3'd7
   } csr_index_type;

   // One entry of the per-neuron state memory.
   typedef struct packed {
      logic [WORD_W-1:0] voltage;
      logic [WORD_W-1:0] last_tick;
      logic              has_spiked;
   } neuron_state_type;

   // Per-transaction tag that travels down the pipeline.
   typedef struct packed {
      logic [INDEX_W-1:0] neuron_index;
      logic               in_range;
      logic [WORD_W-1:0]  tick;
      logic [WORD_W-1:0]  bin;
   } item_tag_type;

endpackage

// ===== rtl/lif_neuron_population_update.sv =====
// Leaky integrate-and-fire population update: one neuron update per transaction.
// Depends on lnpu_pkg and lif_neuron_population_update_assert.svh.
//
// The block takes one neuron update per clock when not stalled and returns one result
// per update, through the stages in order (state read, multiply, partial sums, final
// sum with rounding, saturation and threshold, then the output register). Neuron
// voltage, last spike tick and spike flag sit in one single-port-write memory of
// NEURONS words; an update is written back as it leaves the last compute stage. A
// transaction whose neuron is still in one of the three compute stages waits until
// that update has been written back; distinct neurons stream at one per cycle while
// the result channel does not stall. After reset the block clears the state memory
// and takes no transaction meanwhile; configuration writes are taken also while clearing.
module lif_neuron_population_update #(
   parameter int NEURONS = lnpu_pkg::NEURONS_DEFAULT
) (
   input  logic                                         clock,
   input  logic                                         reset,
   // Input channel.
   input  logic                                         req_valid,
   output logic                                         req_stall,
   input  logic        [lnpu_pkg::INDEX_W-1:0]          req_neuron_index,
   input  logic signed [lnpu_pkg::NOISE_W-1:0]          req_common_noise,
   input  logic signed [lnpu_pkg::NOISE_W-1:0]          req_own_noise,
   input  logic                                         req_last_in_tick,
   // Result channel.
   output logic                                         rsp_valid,
   input  logic                                         rsp_stall,
   output logic        [lnpu_pkg::INDEX_W-1:0]          rsp_neuron_out,
   output logic                                         rsp_spiked,
   output logic        [lnpu_pkg::WORD_W-1:0]           rsp_bin_index,
   output logic signed [lnpu_pkg::WORD_W-1:0]           rsp_voltage,
   // Configuration port.
   input  logic                                         csr_write_enable,
   input  logic        [lnpu_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic        [lnpu_pkg::WORD_W-1:0]           csr_write_data
);
   import lnpu_pkg::*;

`include "lif_neuron_population_update_assert.svh"

   localparam int ADDR_W = (NEURONS > 1) ? $clog2(NEURONS) : 1;
   localparam int EXT_W  = ADDR_W + INDEX_W;

   // Configuration registers.
   logic        [DECAY_W-1:0] decay_ff;
   logic signed [WORD_W-1:0]  common_gain_ff;
   logic signed [WORD_W-1:0]  private_gain_ff;
   logic signed [WORD_W-1:0]  drive_term_ff;
   logic signed [WORD_W-1:0]  threshold_ff;
   logic signed [WORD_W-1:0]  reset_voltage_ff;
   logic        [TICKS_W-1:0] refractory_ticks_ff;
   logic        [TICKS_W-1:0] bin_ticks_ff;

   // Global time state.
   logic [WORD_W-1:0]  tick_count_ff;
   logic [WORD_W-1:0]  current_bin_ff;
   logic [TICKS_W-1:0] ticks_into_bin_ff;
   logic [TICKS_W:0]   ticks_into_bin_inc;

   // Clearing pass.
   logic              clearing_ff;
   logic [ADDR_W-1:0] clr_addr_ff;

   // State memory.
   neuron_state_type mem [NEURONS];
   neuron_state_type rd_ff;
   logic             mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   neuron_state_type mem_wdata;

   // Pipeline control.
   logic req_accept;
   logic hazard;
   logic s1_en;
   logic s2_en;
   logic s3_en;
   logic out_en;
   logic s3_move;
   logic wb_en;

   // Stage 1: tag, noise and state read.
   logic                      s1_valid_ff;
   item_tag_type              s1_tag_ff;
   logic signed [NOISE_W-1:0] s1_cn_ff;
   logic signed [NOISE_W-1:0] s1_on_ff;
   item_tag_type              s1_tag_in;
   logic [EXT_W-1:0]          req_idx_ext;
   logic [ADDR_W-1:0]         rd_addr;
   logic [WORD_W-1:0]         s1_tick_diff;
   logic                      s1_active;
   logic signed [49:0]        prod_v_in;
   logic signed [47:0]        prod_c_in;
   logic signed [47:0]        prod_p_in;

   // Stage 2: products.
   logic               s2_valid_ff;
   item_tag_type       s2_tag_ff;
   neuron_state_type   s2_state_ff;
   logic               s2_active_ff;
   logic signed [49:0] prod_v_ff;
   logic signed [47:0] prod_c_ff;
   logic signed [47:0] prod_p_ff;
   logic signed [SUM_W-1:0] sum_a_in;
   logic signed [SUM_W-1:0] sum_b_in;

   // Stage 3: partial sums.
   logic                    s3_valid_ff;
   item_tag_type            s3_tag_ff;
   neuron_state_type        s3_state_ff;
   logic                    s3_active_ff;
   logic signed [SUM_W-1:0] sum_a_ff;
   logic signed [SUM_W-1:0] sum_b_ff;
   logic signed [SUM_W-1:0] total;
   logic [SUM_W-17:0]       shifted;
   logic                    no_ovf;
   logic signed [WORD_W-1:0] sat_v;
   logic                    spike;
   logic [EXT_W-1:0]        s3_idx_ext;

   // Output register.
   logic                     rsp_valid_ff;
   logic [INDEX_W-1:0]       rsp_neuron_ff;
   logic                     rsp_spiked_ff;
   logic [WORD_W-1:0]        rsp_bin_ff;
   logic signed [WORD_W-1:0] rsp_voltage_ff;
   logic                     rsp_spiked_in;
   logic [WORD_W-1:0]        rsp_bin_in;
   logic signed [WORD_W-1:0] rsp_voltage_in;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff            <= DECAY_RESET;
         common_gain_ff      <= '0;
         private_gain_ff     <= '0;
         drive_term_ff       <= '0;
         threshold_ff        <= THRESHOLD_RESET;
         reset_voltage_ff    <= '0;
         refractory_ticks_ff <= '0;
         bin_ticks_ff        <= BIN_TICKS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_DECAY:            decay_ff            <= csr_write_data[DECAY_W-1:0];
            CSR_COMMON_GAIN:      common_gain_ff      <= csr_write_data;
            CSR_PRIVATE_GAIN:     private_gain_ff     <= csr_write_data;
            CSR_DRIVE_TERM:       drive_term_ff       <= csr_write_data;
            CSR_THRESHOLD:        threshold_ff        <= csr_write_data;
            CSR_RESET_VOLTAGE:    reset_voltage_ff    <= csr_write_data;
            CSR_REFRACTORY_TICKS: refractory_ticks_ff <= csr_write_data[TICKS_W-1:0];
            CSR_BIN_TICKS:        bin_ticks_ff        <= csr_write_data[TICKS_W-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline enables: a stage loads when it is empty or its content moves on.
   assign out_en  = !rsp_valid_ff || !rsp_stall;
   assign s3_en   = !s3_valid_ff || out_en;
   assign s2_en   = !s2_valid_ff || s3_en;
   assign s1_en   = !s1_valid_ff || s2_en;
   assign s3_move = s3_valid_ff && out_en;

   // A neuron still in a compute stage has not been written back yet.
   assign hazard = (s1_valid_ff && s1_tag_ff.neuron_index == req_neuron_index) ||
                   (s2_valid_ff && s2_tag_ff.neuron_index == req_neuron_index) ||
                   (s3_valid_ff && s3_tag_ff.neuron_index == req_neuron_index);

   assign req_stall  = clearing_ff || !s1_en || hazard;
   assign req_accept = req_valid && !req_stall;

   // Time and bin tracking; a transaction sees the tick before its own advance.
   assign ticks_into_bin_inc = {1'b0, ticks_into_bin_ff} + 17'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff     <= '0;
         current_bin_ff    <= '0;
         ticks_into_bin_ff <= '0;
      end else if (req_accept && req_last_in_tick) begin
         tick_count_ff <= tick_count_ff + 32'd1;
         if (tick_count_ff != '0) begin
            if (ticks_into_bin_inc >= {1'b0, bin_ticks_ff}) begin
               ticks_into_bin_ff <= '0;
               current_bin_ff    <= current_bin_ff + 32'd1;
            end else begin
               ticks_into_bin_ff <= ticks_into_bin_inc[TICKS_W-1:0];
            end
         end
      end
   end

   // Clearing pass over the state memory after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(NEURONS - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // Stage 1 tag from the incoming transaction.
   assign req_idx_ext = {{ADDR_W{1'b0}}, req_neuron_index};
   assign rd_addr     = req_idx_ext[ADDR_W-1:0];

   always_comb begin
      s1_tag_in.neuron_index = req_neuron_index;
      s1_tag_in.in_range     = req_idx_ext < EXT_W'(NEURONS);
      s1_tag_in.tick         = tick_count_ff;
      s1_tag_in.bin          = current_bin_ff;
   end

   // State memory: one write port, one registered read port.
   assign wb_en     = s3_move && s3_active_ff;
   assign s3_idx_ext = {{ADDR_W{1'b0}}, s3_tag_ff.neuron_index};
   assign mem_we    = clearing_ff || wb_en;
   assign mem_waddr = clearing_ff ? clr_addr_ff : s3_idx_ext[ADDR_W-1:0];

   always_comb begin
      mem_wdata = '0;
      if (!clearing_ff) begin
         mem_wdata.voltage    = spike ? reset_voltage_ff : sat_v;
         mem_wdata.last_tick  = spike ? s3_tag_ff.tick : s3_state_ff.last_tick;
         mem_wdata.has_spiked = spike || s3_state_ff.has_spiked;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (s1_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // Stage 1 registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_tag_ff <= s1_tag_in;
         s1_cn_ff  <= req_common_noise;
         s1_on_ff  <= req_own_noise;
      end
   end

   // Stage 1 work: refractory check and the three products.
   assign s1_tick_diff = s1_tag_ff.tick - rd_ff.last_tick;
   assign s1_active    = s1_tag_ff.in_range &&
                         (!rd_ff.has_spiked || s1_tick_diff > {16'd0, refractory_ticks_ff});
   assign prod_v_in = $signed(rd_ff.voltage) * $signed({1'b0, decay_ff});
   assign prod_c_in = common_gain_ff * s1_cn_ff;
   assign prod_p_in = private_gain_ff * s1_on_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_tag_ff    <= s1_tag_ff;
         s2_state_ff  <= rd_ff;
         s2_active_ff <= s1_active;
         prod_v_ff    <= prod_v_in;
         prod_c_ff    <= prod_c_in;
         prod_p_ff    <= prod_p_in;
      end
   end

   // Stage 2 work: bring every term to 32 fraction bits, form two partial sums.
   assign sum_a_in = SUM_W'(prod_v_ff) + SUM_W'($signed({prod_c_ff, 4'b0000}));
   assign sum_b_in = SUM_W'($signed({prod_p_ff, 4'b0000})) +
                     SUM_W'($signed({drive_term_ff, 16'h0000})) +
                     SUM_W'(32768);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_tag_ff    <= s2_tag_ff;
         s3_state_ff  <= s2_state_ff;
         s3_active_ff <= s2_active_ff;
         sum_a_ff     <= sum_a_in;
         sum_b_ff     <= sum_b_in;
      end
   end

   // Stage 3 work: final sum, floor to 16 fraction bits, saturate, threshold.
   assign total   = sum_a_ff + sum_b_ff;
   assign shifted = total[SUM_W-1:16];
   assign no_ovf  = (&shifted[SUM_W-17:WORD_W-1]) || !(|shifted[SUM_W-17:WORD_W-1]);
   assign sat_v   = no_ovf ? $signed(shifted[WORD_W-1:0]) :
                    (shifted[SUM_W-17] ? $signed(32'h8000_0000) : $signed(32'h7FFF_FFFF));
   assign spike   = s3_active_ff && (sat_v > threshold_ff);

   // Result of the transaction leaving stage 3.
   always_comb begin
      rsp_spiked_in  = spike;
      rsp_bin_in     = spike ? s3_tag_ff.bin : '0;
      rsp_voltage_in = '0;
      if (s3_active_ff) begin
         rsp_voltage_in = spike ? reset_voltage_ff : sat_v;
      end else if (s3_tag_ff.in_range) begin
         rsp_voltage_in = $signed(s3_state_ff.voltage);
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         rsp_neuron_ff  <= s3_tag_ff.neuron_index;
         rsp_spiked_ff  <= rsp_spiked_in;
         rsp_bin_ff     <= rsp_bin_in;
         rsp_voltage_ff <= rsp_voltage_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_neuron_out = rsp_neuron_ff;
   assign rsp_spiked     = rsp_spiked_ff;
   assign rsp_bin_index  = rsp_bin_ff;
   assign rsp_voltage    = rsp_voltage_ff;

   // Checks on the interlock, write port sharing and result consistency.
   `LNPU_ASSERT_SAME(a_no_wb_while_clearing, clock, reset, clearing_ff, !wb_en)
   `LNPU_ASSERT_SAME(a_no_same_neuron_s1_s2, clock, reset,
                     s1_valid_ff && s2_valid_ff && s1_tag_ff.in_range,
                     s1_tag_ff.neuron_index != s2_tag_ff.neuron_index)
   `LNPU_ASSERT_SAME(a_spike_sets_reset_voltage, clock, reset,
                     rsp_valid && rsp_spiked, rsp_voltage == reset_voltage_ff)
   `LNPU_ASSERT_NEXT(a_accept_enters_stage1, clock, reset,
                     req_valid && !req_stall, s1_valid_ff)

endmodule
